[src/tclt_pkg.sv]
// Package for the TCP connection lookup table: commands, status codes, item types.
// No dependencies.
package tclt_pkg;

    localparam int unsigned TableEntriesDefault = 16;
    localparam int unsigned QueueDepth          = 2;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_ZERO_PORT = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // one classified command as it passes from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic        syn_flag;
        logic        as_listener;
        logic [3:0]  slot_index;
        logic        zero_port;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] hit_slot;
        logic       from_listener;
        logic [1:0] wildcard_count;
    } t_res;

endpackage

[src/tclt_front.sv]
// Front end: accepts command words, flags a zero local port, holds a short queue.
// Depends on tclt_pkg.
module tclt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tclt_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output tclt_pkg::t_cmd o_cmd
);
    import tclt_pkg::*;

    localparam int unsigned PW = $clog2(QueueDepth);

    t_cmd          r_q [QueueDepth];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push, pop;
    t_cmd          cls;

    // classify
    always_comb begin
        cls = i_cmd;
        cls.zero_port = (i_cmd.local_port == 16'd0);
    end

    assign o_ready = (r_cnt != (PW+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (PW+1)'(QueueDepth) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !pop) else $error("queue underflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
`endif
endmodule

[src/tclt_back.sv]
// Back end: table storage and a sequential scan over the slots per lookup or insert command.
// Depends on tclt_pkg.
module tclt_back #(
    parameter int unsigned TABLE_ENTRIES = tclt_pkg::TableEntriesDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tclt_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output tclt_pkg::t_res o_res
);
    import tclt_pkg::*;

    localparam int unsigned SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // table memory
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic        m_lis  [TABLE_ENTRIES];
    logic [31:0] m_lip  [TABLE_ENTRIES];
    logic [15:0] m_lpt  [TABLE_ENTRIES];
    logic [31:0] m_rip  [TABLE_ENTRIES];
    logic [15:0] m_rpt  [TABLE_ENTRIES];
    logic [31:0] m_stp  [TABLE_ENTRIES];
    logic [31:0] r_ctr;

    t_state  r_st;
    t_cmd    r_c;
    logic [SW-1:0] r_i;
    logic    r_run_hit, r_found, r_dup, r_free_ok;
    logic [SW-1:0] r_run_slot, r_best, r_free;
    logic [1:0]    r_bwc;
    logic [31:0]   r_bage;
    t_res    r_res;
    t_res    n_res;

    // registered read of the slot being scanned
    logic        rd_lis;
    logic [31:0] rd_lip, rd_rip, rd_stp;
    logic [15:0] rd_lpt, rd_rpt;
    logic        rd_v;
    always_ff @(posedge i_clk) begin
        rd_lis <= m_lis[r_i];
        rd_lip <= m_lip[r_i];
        rd_lpt <= m_lpt[r_i];
        rd_rip <= m_rip[r_i];
        rd_rpt <= m_rpt[r_i];
        rd_stp <= m_stp[r_i];
    end

    logic [SW-1:0] r_ri;
    logic          r_rdv, r_last;
    assign rd_v = r_valid[r_ri];

    // compare logic on the registered slot
    logic        same4, lmatch;
    logic [1:0]  wc;
    logic [31:0] age;
    always_comb begin
        same4  = (rd_lip == r_c.local_ip) && (rd_lpt == r_c.local_port) &&
                 (rd_rip == r_c.remote_ip) && (rd_rpt == r_c.remote_port);
        lmatch = (rd_lpt == r_c.local_port) &&
                 (rd_lip == 32'd0 || rd_lip == r_c.local_ip) &&
                 (rd_rip == 32'd0 || rd_rip == r_c.remote_ip) &&
                 (rd_rpt == 16'd0 || rd_rpt == r_c.remote_port);
        wc     = 2'(rd_lip == 32'd0) + 2'(rd_rip == 32'd0) + 2'(rd_rpt == 16'd0);
        age    = r_ctr - rd_stp;
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_res   = r_res;

    logic rm_ok;
    assign rm_ok = (32'(r_c.slot_index) < TABLE_ENTRIES) &&
                   r_valid[SW'(r_c.slot_index)];

    // result word for the finished command
    always_comb begin
        n_res = '{status: ST_MISS, hit_slot: 4'd0,
                  from_listener: 1'b0, wildcard_count: 2'd0};
        case (r_c.cmd)
            CMD_LOOKUP: begin
                if (r_run_hit) begin
                    n_res.status   = ST_OK;
                    n_res.hit_slot = 4'(r_run_slot);
                end else if (r_found) begin
                    n_res = '{status: ST_OK, hit_slot: 4'(r_best),
                              from_listener: 1'b1, wildcard_count: r_bwc};
                end
            end
            CMD_INSERT: begin
                if (r_c.zero_port) n_res.status = ST_ZERO_PORT;
                else if (r_dup)    n_res.status = ST_DUP;
                else if (!r_free_ok) n_res.status = ST_FULL;
                else begin
                    n_res.status   = ST_OK;
                    n_res.hit_slot = 4'(r_free);
                end
            end
            CMD_REMOVE: begin
                n_res.hit_slot = r_c.slot_index;
                if (rm_ok) n_res.status = ST_OK;
            end
            default: ;
        endcase
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (r_st == S_DONE && r_c.cmd == CMD_INSERT && !r_c.zero_port && !r_dup && r_free_ok) begin
            m_lis[r_free] <= r_c.as_listener;
            m_lip[r_free] <= r_c.local_ip;
            m_lpt[r_free] <= r_c.local_port;
            m_rip[r_free] <= r_c.remote_ip;
            m_rpt[r_free] <= r_c.remote_port;
            m_stp[r_free] <= r_ctr;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= '0;
            r_ctr   <= '0;
            r_rdv   <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_c       <= i_cmd;
                        r_i       <= '0;
                        r_run_hit <= 1'b0;
                        r_found   <= 1'b0;
                        r_dup     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_bwc     <= '0;
                        r_bage    <= '0;
                        r_best    <= '0;
                        r_free    <= '0;
                        r_run_slot <= '0;
                        if (i_cmd.cmd == CMD_LOOKUP ||
                            (i_cmd.cmd == CMD_INSERT && i_cmd.local_port != 16'd0)) begin
                            r_st <= S_SCAN;
                        end else begin
                            r_st <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // issue reads, evaluate previous slot
                    if (!r_last || !r_rdv) begin
                        r_ri   <= r_i;
                        r_rdv  <= 1'b1;
                        r_last <= (32'(r_i) == TABLE_ENTRIES - 1);
                        if (32'(r_i) != TABLE_ENTRIES - 1) r_i <= r_i + 1'b1;
                    end
                    if (r_rdv) begin
                        if (rd_v) begin
                            if (r_c.cmd == CMD_LOOKUP) begin
                                if (!rd_lis && same4 && !r_run_hit) begin
                                    r_run_hit  <= 1'b1;
                                    r_run_slot <= r_ri;
                                end
                                if (rd_lis && r_c.syn_flag && lmatch &&
                                    (!r_found || wc < r_bwc ||
                                     (wc == r_bwc && age < r_bage))) begin
                                    r_found <= 1'b1;
                                    r_best  <= r_ri;
                                    r_bwc   <= wc;
                                    r_bage  <= age;
                                end
                            end else if (rd_lis == r_c.as_listener && same4) begin
                                r_dup <= 1'b1;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_ri;
                        end
                        if (r_last) begin
                            r_st   <= S_DONE;
                            r_rdv  <= 1'b0;
                            r_last <= 1'b0;
                        end
                    end
                end
                S_DONE: begin
                    r_res <= n_res;
                    case (r_c.cmd)
                        CMD_INSERT: begin
                            if (!r_c.zero_port && !r_dup && r_free_ok) begin
                                r_valid[r_free] <= 1'b1;
                                r_ctr <= r_ctr + 32'd1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (rm_ok) r_valid[SW'(r_c.slot_index)] <= 1'b0;
                        end
                        default: ;
                    endcase
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_res)) else $error("result moved");
    a_ctr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctr != $past(r_ctr) |-> $past(r_st) == S_DONE) else $error("counter slip");
    a_listener_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.from_listener |-> o_res.status == ST_OK) else $error("bad flag");
`endif
endmodule

[src/tcp_connection_lookup_table_top.sv]
// Channel   Dir  tdata fields (low bit up)                              tuser
// s_axis    in   cmd, local_ip, local_port, remote_ip, remote_port,     -
//                syn_flag, as_listener, slot_index (104 bits)
// m_axis    out  status, hit_slot, from_listener, wildcard_count (16)   -
// Lookup and insert scan the table memory one slot a cycle; remove and
// zero-port inserts skip the scan.
// Synchronous active-low reset empties the table and zeroes the insert stamp.
// The two-word command queue lets s_axis take up to two commands while a result waits on m_axis.
// Depends on tclt_pkg, tclt_front, tclt_back.
module tcp_connection_lookup_table_top #(
    parameter int unsigned TABLE_ENTRIES = tclt_pkg::TableEntriesDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // cmd, local_ip, local_port, remote_ip,
                                        // remote_port, syn_flag, as_listener, slot_index
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata   // status, hit_slot, from_listener, wildcard_count
);
    import tclt_pkg::*;

    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;

    // unpack input word
    always_comb begin
        in_cmd.cmd         = s_axis_tdata[1:0];
        in_cmd.local_ip    = s_axis_tdata[33:2];
        in_cmd.local_port  = s_axis_tdata[49:34];
        in_cmd.remote_ip   = s_axis_tdata[81:50];
        in_cmd.remote_port = s_axis_tdata[97:82];
        in_cmd.syn_flag    = s_axis_tdata[98];
        in_cmd.as_listener = s_axis_tdata[99];
        in_cmd.slot_index  = s_axis_tdata[103:100];
        in_cmd.zero_port   = 1'b0;
    end

    tclt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    tclt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {6'd0, res.wildcard_count, res.from_listener,
                           res.hit_slot, res.status};
endmodule
